>>> src/ps2_mouse_port_controller_defines.svh
// assertion macros for the ps2 mouse port controller checker
`ifndef PS2_MOUSE_PORT_CONTROLLER_DEFINES_SVH
`define PS2_MOUSE_PORT_CONTROLLER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PS2MP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define PS2MP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset
`define PS2MP_ASSERT_NEXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ps2mp_pkg.sv
// shared types, constants and helpers of the ps2 mouse port controller
package ps2mp_pkg;

  localparam int QUEUE_DEPTH = 256;  // multiple of four (four byte banks)
  localparam int MIN_FREE    = 12;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int BANKS  = 4;
  localparam int BANK_W = 2;
  localparam int ROWS   = QUEUE_DEPTH / BANKS;
  localparam int ROW_W  = PTR_W - BANK_W;

  localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W:0] USED_MAX  = (PTR_W + 1)'(QUEUE_DEPTH - 1 - MIN_FREE);

  localparam logic [2:0] OP_MOVE    = 3'd0;
  localparam logic [2:0] OP_PRESS   = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;
  localparam logic [2:0] OP_RX_TICK = 3'd5;
  localparam logic [2:0] OP_TX_DONE = 3'd6;

  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_DATA = 2'd1;

  localparam int CB_RRDY = 0;
  localparam int CB_RIEN = 1;
  localparam int CB_XRDY = 2;
  localparam int CB_XIEN = 3;

  localparam logic [7:0] CMD_RESET   = 8'hFF;
  localparam logic [7:0] CMD_DISABLE = 8'hF5;
  localparam logic [7:0] CMD_ENABLE  = 8'hF4;
  localparam logic [7:0] ANS_ACK     = 8'hFA;
  localparam logic [7:0] ANS_BAT_OK  = 8'hAA;
  localparam logic [7:0] ANS_ID      = 8'h00;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [15:0] abs_x;
    logic signed [15:0] abs_y;
    logic [2:0]        button_code;
    logic [1:0]        reg_index;
    logic [7:0]        write_value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       irq_line;
    logic       bus_error;
  } result_t;

  // up to three bytes at three queue positions in one cycle
  typedef struct packed {
    logic [2:0]      en;
    ptr_t [2:0]      pos;
    logic [2:0][7:0] data;
  } queue_wr_t;

  typedef struct packed {
    logic en;
    ptr_t pos;
  } queue_rd_t;

  // circular pointer advance by 0..3
  function automatic ptr_t ptr_add(input ptr_t p, input logic [1:0] k);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {{(PTR_W - 1){1'b0}}, k};
    if (s >= DEPTH_EXT) begin
      s = s - DEPTH_EXT;
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

>>> src/ps2mp_if.sv
// valid/ready channel interfaces for items and results
interface ps2mp_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [15:0] abs_x;
  logic signed [15:0] abs_y;
  logic [2:0]        button_code;
  logic [1:0]        reg_index;
  logic [7:0]        write_value;

  modport source (output valid, opcode, abs_x, abs_y, button_code, reg_index, write_value,
                  input ready);
  modport sink (input valid, opcode, abs_x, abs_y, button_code, reg_index, write_value,
                output ready);
endinterface

interface ps2mp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       irq_line;
  logic       bus_error;

  modport source (output valid, read_value, irq_line, bus_error, input ready);
  modport sink (input valid, read_value, irq_line, bus_error, output ready);
endinterface

>>> src/ps2mp_queue.sv
// mouse byte queue: four byte banks, registered read, start-up bytes
module ps2mp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  ps2mp_pkg::queue_wr_t wr,
  input  ps2mp_pkg::queue_rd_t rd,
  output logic [7:0]           rx_byte
);
  import ps2mp_pkg::*;

  logic             bank_we  [BANKS];
  logic [ROW_W-1:0] bank_row [BANKS];
  logic [7:0]       bank_din [BANKS];
  logic [7:0]       bank_q   [BANKS];

  logic [BANK_W-1:0] sel_q;
  logic              use_const;
  logic [7:0]        const_val;
  logic [1:0]        pre;
  logic [1:0]        pre_next;

  // route each written byte to the bank its position falls in
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_we[b]  = 1'b0;
      bank_row[b] = '0;
      bank_din[b] = '0;
      for (int k = 0; k < 3; k++) begin
        if (wr.en[k] && (wr.pos[k][BANK_W-1:0] == BANK_W'(b))) begin
          bank_we[b]  = 1'b1;
          bank_row[b] = wr.pos[k][PTR_W-1:BANK_W];
          bank_din[b] = wr.data[k];
        end
      end
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[bank_row[b]] <= bank_din[b];
      end
      if (rd.en) begin
        bank_q[b] <= mem[rd.pos[PTR_W-1:BANK_W]];
      end
    end
  end

  // positions 0 and 1 hold the power-on bytes until first overwritten
  always_comb begin
    pre_next = pre;
    for (int k = 0; k < 3; k++) begin
      if (wr.en[k] && (wr.pos[k] == ptr_t'(0))) pre_next[0] = 1'b0;
      if (wr.en[k] && (wr.pos[k] == ptr_t'(1))) pre_next[1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre       <= 2'b11;
      use_const <= 1'b1;
      const_val <= '0;
      sel_q     <= '0;
    end else begin
      pre <= pre_next;
      if (rd.en) begin
        sel_q     <= rd.pos[BANK_W-1:0];
        use_const <= ((rd.pos == ptr_t'(0)) && pre[0]) || ((rd.pos == ptr_t'(1)) && pre[1]);
        const_val <= (rd.pos == ptr_t'(0)) ? ANS_BAT_OK : ANS_ID;
      end
    end
  end

  assign rx_byte = use_const ? const_val : bank_q[sel_q];

endmodule

>>> src/ps2mp_ctrl.sv
// mouse emulation and port registers: one item's state update per step
module ps2mp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  ps2mp_pkg::item_t     item,
  input  logic [7:0]           rx_byte,
  output ps2mp_pkg::queue_wr_t wr,
  output ps2mp_pkg::queue_rd_t rd,
  output ps2mp_pkg::result_t   res
);
  import ps2mp_pkg::*;

  ptr_t              head, head_next;
  ptr_t              tail, tail_next;
  logic signed [15:0] last_x, last_x_next;
  logic signed [15:0] last_y, last_y_next;
  logic [2:0]        buttons, buttons_next;
  logic              reporting, reporting_next;
  logic [3:0]        ctrl, ctrl_next;
  logic [7:0]        cmd, cmd_next;
  logic              irq, irq_next;

  logic [PTR_W:0]    used;
  logic              free_ok;
  logic signed [16:0] dx, dy;
  logic [7:0]        pkt0;
  logic [2:0]        mask;
  logic [3:0]        ctrl_w;
  queue_wr_t         wr_c;
  queue_rd_t         rd_c;

  function automatic logic [2:0] button_mask(input logic [2:0] code);
    case (code)
      3'd1:    return 3'b001;
      3'd2:    return 3'b100;
      3'd3:    return 3'b010;
      default: return 3'b000;
    endcase
  endfunction

  assign used = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                               : ({1'b0, tail} + DEPTH_EXT - {1'b0, head});
  assign free_ok = (used <= USED_MAX);

  assign dx   = {item.abs_x[15], item.abs_x} - {last_x[15], last_x};
  assign dy   = {last_y[15], last_y} - {item.abs_y[15], item.abs_y};
  assign mask = button_mask(item.button_code);

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    last_x_next    = last_x;
    last_y_next    = last_y;
    buttons_next   = buttons;
    reporting_next = reporting;
    ctrl_next      = ctrl;
    cmd_next       = cmd;
    irq_next       = irq;
    wr_c           = '0;
    rd_c           = '0;
    res            = '0;
    pkt0           = '0;
    ctrl_w         = '0;

    case (item.opcode)
      OP_MOVE: begin
        if (reporting) begin
          last_x_next = item.abs_x;
          last_y_next = item.abs_y;
          pkt0 = {(dy > 17'sd255) || (dy < -17'sd255), (dx > 17'sd255) || (dx < -17'sd255),
                  dy[16], dx[16], 1'b1, buttons};
          if (free_ok) begin
            wr_c.en   = 3'b111;
            wr_c.pos  = {ptr_add(tail, 2'd2), ptr_add(tail, 2'd1), tail};
            wr_c.data = {dy[7:0], dx[7:0], pkt0};
            tail_next = ptr_add(tail, 2'd3);
          end
        end
      end
      OP_PRESS, OP_RELEASE: begin
        if (reporting) begin
          buttons_next = (item.opcode == OP_PRESS) ? (buttons | mask) : (buttons & ~mask);
          if (free_ok) begin
            wr_c.en   = 3'b111;
            wr_c.pos  = {ptr_add(tail, 2'd2), ptr_add(tail, 2'd1), tail};
            wr_c.data = {8'h00, 8'h00, {5'b00001, buttons_next}};
            tail_next = ptr_add(tail, 2'd3);
          end
        end
      end
      OP_READ: begin
        case (item.reg_index)
          REG_CTRL: res.read_value = {4'b0000, ctrl};
          REG_DATA: begin
            ctrl_next[CB_RRDY] = 1'b0;
            if (ctrl[CB_RIEN]) irq_next = 1'b0;
            res.read_value = rx_byte;
          end
          default: res.bus_error = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (item.reg_index)
          REG_CTRL: begin
            ctrl_w = ctrl;
            ctrl_w[CB_RIEN] = item.write_value[CB_RIEN];
            ctrl_w[CB_XIEN] = item.write_value[CB_XIEN];
            ctrl_next = ctrl_w;
            irq_next  = (ctrl_w[CB_RIEN] && ctrl_w[CB_RRDY]) ||
                        (ctrl_w[CB_XIEN] && ctrl_w[CB_XRDY]);
          end
          REG_DATA: begin
            cmd_next = item.write_value;
            ctrl_next[CB_XRDY] = 1'b0;
            if (ctrl[CB_XIEN]) irq_next = 1'b0;
          end
          default: res.bus_error = 1'b1;
        endcase
      end
      OP_RX_TICK: begin
        if ((head != tail) && !ctrl[CB_RRDY]) begin
          rd_c.en  = 1'b1;
          rd_c.pos = head;
          head_next = ptr_add(head, 2'd1);
          ctrl_next[CB_RRDY] = 1'b1;
          if (ctrl[CB_RIEN]) irq_next = 1'b1;
        end
      end
      OP_TX_DONE: begin
        case (cmd)
          CMD_RESET: begin
            // empty queue always has room for the three answer bytes
            reporting_next = 1'b0;
            last_x_next    = '0;
            last_y_next    = '0;
            buttons_next   = '0;
            head_next      = '0;
            wr_c.en        = 3'b111;
            wr_c.pos       = {ptr_t'(2), ptr_t'(1), ptr_t'(0)};
            wr_c.data      = {ANS_ID, ANS_BAT_OK, ANS_ACK};
            tail_next      = ptr_t'(3);
          end
          default: begin
            if (cmd == CMD_DISABLE) reporting_next = 1'b0;
            if (cmd == CMD_ENABLE)  reporting_next = 1'b1;
            if (free_ok) begin
              wr_c.en     = 3'b001;
              wr_c.pos[0] = tail;
              wr_c.data[0] = ANS_ACK;
              tail_next   = ptr_add(tail, 2'd1);
            end
          end
        endcase
        ctrl_next[CB_XRDY] = 1'b1;
        if (ctrl[CB_XIEN]) irq_next = 1'b1;
      end
      default: ;
    endcase

    res.irq_line = irq_next;
  end

  always_comb begin
    wr    = wr_c;
    wr.en = wr_c.en & {3{step}};
    rd    = rd_c;
    rd.en = rd_c.en & step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= ptr_t'(2);
      last_x    <= '0;
      last_y    <= '0;
      buttons   <= '0;
      reporting <= 1'b0;
      ctrl      <= 4'b0100;
      cmd       <= '0;
      irq       <= 1'b0;
    end else if (step) begin
      head      <= head_next;
      tail      <= tail_next;
      last_x    <= last_x_next;
      last_y    <= last_y_next;
      buttons   <= buttons_next;
      reporting <= reporting_next;
      ctrl      <= ctrl_next;
      cmd       <= cmd_next;
      irq       <= irq_next;
    end
  end

endmodule

>>> src/ps2_mouse_port_controller.sv
// top level of the ps2 mouse port controller: input and result registers
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   opcode, abs_x, abs_y, button_code, reg_index, write_value
//   result   out  valid/ready   read_value, irq_line, bus_error
//
// one item per cycle while the result sink keeps up; each item passes through the
// input register and then the result register
// the byte queue is four byte banks with one write port each, so a 3-byte packet is
// written in the same cycle as its item is processed
// reset needs no clearing pass: the two power-on bytes come from flags that
// retire once their positions are overwritten
// a result waiting on a stalled sink holds its register; the input register
// still takes an item, and ready drops only while both registers are full
module ps2_mouse_port_controller (
  input  logic        clk,
  input  logic        rst,
  ps2mp_in_if.sink    item,
  ps2mp_out_if.source result
);
  import ps2mp_pkg::*;

  item_t     item_q;    // registered transaction, no reset needed
  logic      item_full;
  logic      step;      // item in the input register gets processed this cycle
  result_t   res_next;
  result_t   res_q;
  logic      res_full;
  logic [7:0] rx_byte;
  queue_wr_t q_wr;
  queue_rd_t q_rd;

  // process whenever the result register is free or being emptied
  assign step       = item_full && (!res_full || result.ready);
  assign item.ready = !item_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item.ready) begin
      item_full <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.opcode      <= item.opcode;
      item_q.abs_x       <= item.abs_x;
      item_q.abs_y       <= item.abs_y;
      item_q.button_code <= item.button_code;
      item_q.reg_index   <= item.reg_index;
      item_q.write_value <= item.write_value;
    end
  end

  ps2mp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (item_q),
    .rx_byte (rx_byte),
    .wr      (q_wr),
    .rd      (q_rd),
    .res     (res_next)
  );

  ps2mp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .rd      (q_rd),
    .rx_byte (rx_byte)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (step) begin
      res_full <= 1'b1;
    end else if (result.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign result.valid      = res_full;
  assign result.read_value = res_q.read_value;
  assign result.irq_line   = res_q.irq_line;
  assign result.bus_error  = res_q.bus_error;

endmodule

>>> src/ps2mp_checker.sv
// port checker for the ps2 mouse port controller and its bind
`include "ps2_mouse_port_controller_defines.svh"

module ps2mp_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] read_value,
  input logic       irq_line,
  input logic       bus_error
);

  // a stalled result keeps its payload
  `PS2MP_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(read_value) && $stable(irq_line) && $stable(bus_error), "stalled result changed")

  // with no result pending the block can always take a transaction
  `PS2MP_ASSERT_IMPL(a_ready_when_empty, clk, rst, !result_valid, item_ready, "input stalled with empty result register")

  // reset leaves no result pending
  `PS2MP_ASSERT_NEXT_ALL(a_reset_empty, clk, rst, !result_valid, "result valid right after reset")

  // an accepted transaction with the result side empty shows up once it has passed the input and result registers
  `PS2MP_ASSERT_NEXT(a_latency, clk, rst, item_valid && item_ready && !result_valid, ##1 result_valid, "result missing two cycles after transaction")

endmodule

bind ps2_mouse_port_controller ps2mp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .read_value   (result.read_value),
  .irq_line     (result.irq_line),
  .bus_error    (result.bus_error)
);

>>> dv/ps2_mouse_port_controller_tb.sv
// testbench for the ps2 mouse port controller: random and directed items checked against a predictor
module ps2_mouse_port_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam logic [1:0] REG_BAD_LO = 2'd2;
  localparam logic [1:0] REG_BAD_HI = 2'd3;

  // button codes on the input and their bits in the packet header
  localparam logic [2:0] BCODE_LEFT   = 3'd1;
  localparam logic [2:0] BCODE_MIDDLE = 3'd2;
  localparam logic [2:0] BCODE_RIGHT  = 3'd3;
  localparam logic [2:0] BTN_LEFT     = 3'b001;
  localparam logic [2:0] BTN_RIGHT    = 3'b010;
  localparam logic [2:0] BTN_MIDDLE   = 3'b100;

  // packet header bits
  localparam logic [7:0] PK_ONE   = 8'h08;
  localparam logic [7:0] PK_XSIGN = 8'h10;
  localparam logic [7:0] PK_YSIGN = 8'h20;
  localparam logic [7:0] PK_XOVF  = 8'h40;
  localparam logic [7:0] PK_YOVF  = 8'h80;
  localparam int DELTA_MAX = 255;

  localparam int POS_MAX    = 32767;
  localparam int POS_MIN    = -32768;
  localparam int DELTA_SPAN = 300;

  typedef enum int {MIX_NORMAL, MIX_FILL, MIX_DRAIN} mix_t;

  // mouse and port state, plus the expected results still in flight
  class mouse_port_scoreboard;
    logic [7:0]  queue_mem [QUEUE_DEPTH];
    int unsigned q_head;
    int unsigned q_tail;
    int          last_x;
    int          last_y;
    logic [2:0]  buttons;
    bit          report_en;
    logic [3:0]  ctrl;
    logic [7:0]  rx_data;
    logic [7:0]  cmd;
    bit          irq;
    result_t     pending_results [$];
    int          errors;
    int          n_checked;
    int          n_packets;
    int          n_dropped;
    int          n_reads;

    function new();
      foreach (queue_mem[i]) queue_mem[i] = 8'h00;
      queue_mem[0] = ANS_BAT_OK;
      queue_mem[1] = ANS_ID;
      q_head = 0;
      q_tail = 2;
      last_x = 0;
      last_y = 0;
      buttons = '0;
      report_en = 1'b0;
      ctrl = '0;
      ctrl[CB_XRDY] = 1'b1;
      rx_data = '0;
      cmd = '0;
      irq = 1'b0;
    endfunction

    function int unsigned queue_space();
      int unsigned used;
      used = (q_tail + QUEUE_DEPTH - q_head) % QUEUE_DEPTH;
      return QUEUE_DEPTH - 1 - used;
    endfunction

    // all n bytes go in, or none when the queue is nearly full
    function void enqueue(input logic [7:0] b0, b1, b2, input int n);
      logic [7:0] seq [3];
      if (queue_space() < MIN_FREE) begin
        n_dropped++;
        return;
      end
      seq = '{b0, b1, b2};
      for (int i = 0; i < n; i++) begin
        queue_mem[q_tail] = seq[i];
        q_tail = (q_tail + 1) % QUEUE_DEPTH;
      end
      if (n == 3) n_packets++;
    endfunction

    function void note_item(input item_t it);
      result_t    r;
      int         nx;
      int         ny;
      int         dx;
      int         dy;
      logic [7:0] hdr;
      logic [2:0] mask;
      r = '0;
      case (it.opcode)
        OP_MOVE: begin
          if (report_en) begin
            nx = {{16{it.abs_x[15]}}, it.abs_x};
            ny = {{16{it.abs_y[15]}}, it.abs_y};
            dx = nx - last_x;
            dy = last_y - ny;  // y axis points the other way
            last_x = nx;
            last_y = ny;
            hdr = PK_ONE | {5'b0, buttons};
            if (dx < 0) hdr |= PK_XSIGN;
            if (dy < 0) hdr |= PK_YSIGN;
            if (dx < -DELTA_MAX || dx > DELTA_MAX) hdr |= PK_XOVF;
            if (dy < -DELTA_MAX || dy > DELTA_MAX) hdr |= PK_YOVF;
            enqueue(hdr, 8'(dx), 8'(dy), 3);
          end
        end
        OP_PRESS, OP_RELEASE: begin
          if (report_en) begin
            case (it.button_code)
              BCODE_LEFT:   mask = BTN_LEFT;
              BCODE_MIDDLE: mask = BTN_MIDDLE;
              BCODE_RIGHT:  mask = BTN_RIGHT;
              default:      mask = '0;
            endcase
            if (it.opcode == OP_PRESS) buttons = buttons | mask;
            else buttons = buttons & ~mask;
            enqueue(PK_ONE | {5'b0, buttons}, 8'h00, 8'h00, 3);
          end
        end
        OP_READ: begin
          case (it.reg_index)
            REG_CTRL: begin
              r.read_value = {4'b0, ctrl};
              n_reads++;
            end
            REG_DATA: begin
              ctrl[CB_RRDY] = 1'b0;
              if (ctrl[CB_RIEN]) irq = 1'b0;
              r.read_value = rx_data;
              n_reads++;
            end
            default: r.bus_error = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (it.reg_index)
            REG_CTRL: begin
              ctrl[CB_RIEN] = it.write_value[CB_RIEN];
              ctrl[CB_XIEN] = it.write_value[CB_XIEN];
              irq = (ctrl[CB_RIEN] && ctrl[CB_RRDY]) || (ctrl[CB_XIEN] && ctrl[CB_XRDY]);
            end
            REG_DATA: begin
              cmd = it.write_value;
              ctrl[CB_XRDY] = 1'b0;
              if (ctrl[CB_XIEN]) irq = 1'b0;
            end
            default: r.bus_error = 1'b1;
          endcase
        end
        OP_RX_TICK: begin
          if (q_head != q_tail && !ctrl[CB_RRDY]) begin
            rx_data = queue_mem[q_head];
            q_head = (q_head + 1) % QUEUE_DEPTH;
            ctrl[CB_RRDY] = 1'b1;
            if (ctrl[CB_RIEN]) irq = 1'b1;
          end
        end
        OP_TX_DONE: begin
          case (cmd)
            CMD_RESET: begin
              report_en = 1'b0;
              q_head = 0;
              q_tail = 0;
              last_x = 0;
              last_y = 0;
              buttons = '0;
              enqueue(ANS_ACK, 8'h00, 8'h00, 1);
              enqueue(ANS_BAT_OK, 8'h00, 8'h00, 1);
              enqueue(ANS_ID, 8'h00, 8'h00, 1);
            end
            CMD_DISABLE: begin
              report_en = 1'b0;
              enqueue(ANS_ACK, 8'h00, 8'h00, 1);
            end
            CMD_ENABLE: begin
              report_en = 1'b1;
              enqueue(ANS_ACK, 8'h00, 8'h00, 1);
            end
            default: enqueue(ANS_ACK, 8'h00, 8'h00, 1);
          endcase
          ctrl[CB_XRDY] = 1'b1;
          if (ctrl[CB_XIEN]) irq = 1'b1;
        end
        default: ;
      endcase
      r.irq_line = irq;
      pending_results.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: read_value %02h irq_line %0b bus_error %0b",
                 $time, got.read_value, got.irq_line, got.bus_error);
        return;
      end
      exp = pending_results.pop_front();
      n_checked++;
      if (got.read_value !== exp.read_value) begin
        errors++;
        $display("%0t: read_value expected %02h actual %02h", $time, exp.read_value,
                 got.read_value);
      end
      if (got.irq_line !== exp.irq_line) begin
        errors++;
        $display("%0t: irq_line expected %0b actual %0b", $time, exp.irq_line, got.irq_line);
      end
      if (got.bus_error !== exp.bus_error) begin
        errors++;
        $display("%0t: bus_error expected %0b actual %0b", $time, exp.bus_error,
                 got.bus_error);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ps2mp_in_if  in_ch ();
  ps2mp_out_if out_ch ();

  ps2_mouse_port_controller dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  mouse_port_scoreboard sb;
  bit quiet;
  int n_sent;
  int n_counted;
  int n_results;
  int hold_left;
  int idle_left;
  bit hold_done;
  int cycle_count;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check each transaction and pace ready, with one long hold-off
  always @(posedge clk) begin : result_side
    result_t got;
    logic    nxt_ready;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.read_value = out_ch.read_value;
      got.irq_line   = out_ch.irq_line;
      got.bus_error  = out_ch.bus_error;
      sb.check_result(got);
      n_results++;
    end
    if (!hold_done && n_results >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      nxt_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (idle_left > 0) begin
      idle_left--;
      nxt_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      idle_left = $urandom_range(1, 5) - 1;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    out_ch.ready <= nxt_ready;
  end

  function automatic item_t rand_fields(input logic [2:0] op);
    item_t it;
    it.opcode      = op;
    it.abs_x       = 16'($urandom);
    it.abs_y       = 16'($urandom);
    it.button_code = 3'($urandom);
    it.reg_index   = 2'($urandom);
    it.write_value = 8'($urandom);
    return it;
  endfunction

  // offer one item, with an occasional gap, and return once it is taken
  task automatic send(input item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= it.opcode;
    in_ch.abs_x       <= it.abs_x;
    in_ch.abs_y       <= it.abs_y;
    in_ch.button_code <= it.button_code;
    in_ch.reg_index   <= it.reg_index;
    in_ch.write_value <= it.write_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // items the mouse simply ignores are not counted toward the run length
    if (!(it.opcode == OP_UNUSED || (it.opcode <= OP_RELEASE && !sb.report_en)))
      n_counted++;
    sb.note_item(it);
    n_sent++;
  endtask

  task automatic plain(input logic [2:0] op);
    send(rand_fields(op));
  endtask

  task automatic move_to(input logic [15:0] x, input logic [15:0] y);
    item_t it;
    it = rand_fields(OP_MOVE);
    it.abs_x = x;
    it.abs_y = y;
    send(it);
  endtask

  task automatic button(input logic [2:0] op, input logic [2:0] code);
    item_t it;
    it = rand_fields(op);
    it.button_code = code;
    send(it);
  endtask

  task automatic reg_read(input logic [1:0] idx);
    item_t it;
    it = rand_fields(OP_READ);
    it.reg_index = idx;
    send(it);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
    item_t it;
    it = rand_fields(OP_WRITE);
    it.reg_index = idx;
    it.write_value = value;
    send(it);
  endtask

  // host sends a command byte and the mouse finishes taking it
  task automatic host_command(input logic [7:0] c);
    reg_write(REG_DATA, c);
    if ($urandom_range(0, 2) == 0) reg_read(REG_CTRL);
    plain(OP_TX_DONE);
  endtask

  // host takes one byte from the mouse
  task automatic fetch_byte();
    plain(OP_RX_TICK);
    if ($urandom_range(0, 2) == 0) reg_read(REG_CTRL);
    reg_read(REG_DATA);
  endtask

  initial begin
    mix_t       mix;
    int         cut [7];
    int         pick;
    int         sel;
    int         next_switch;
    int         goal;
    int         x;
    int         y;
    logic [7:0] c;

    sb = new();
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_MOVE;
    in_ch.abs_x       <= '0;
    in_ch.abs_y       <= '0;
    in_ch.button_code <= '0;
    in_ch.reg_index   <= REG_CTRL;
    in_ch.write_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // power-on bytes, ready flags and the empty queue
    reg_read(REG_CTRL);
    plain(OP_RX_TICK);
    plain(OP_RX_TICK);
    reg_read(REG_DATA);
    reg_write(REG_CTRL, 8'hFF);
    plain(OP_RX_TICK);
    reg_read(REG_DATA);
    plain(OP_RX_TICK);
    // reporting off: move ignored, then enable
    move_to(16'sd100, 16'sd100);
    host_command(CMD_ENABLE);
    // extreme positions and overflowing deltas
    move_to(16'(POS_MAX), 16'(POS_MIN));
    move_to(16'(POS_MIN), 16'(POS_MAX));
    move_to(16'(POS_MIN + 5), 16'(POS_MAX - 3));
    button(OP_PRESS, BCODE_LEFT);
    button(OP_PRESS, BCODE_MIDDLE);
    button(OP_PRESS, BCODE_RIGHT);
    button(OP_PRESS, 3'd0);
    button(OP_RELEASE, 3'd7);
    button(OP_RELEASE, BCODE_MIDDLE);
    reg_read(REG_BAD_LO);
    reg_write(REG_BAD_HI, 8'hFF);
    plain(OP_UNUSED);
    reg_write(REG_CTRL, 8'h00);
    host_command(8'h5A);
    host_command(CMD_DISABLE);
    move_to(16'sd7, -16'sd7);
    host_command(CMD_RESET);

    // random part: sequences with random content, changing mix over time
    goal = n_counted + RANDOM_ITEMS;
    next_switch = 0;
    mix = MIX_NORMAL;
    while (n_counted < goal) begin
      quiet = (n_counted >= goal - QUIET_TAIL);
      if (n_counted >= next_switch) begin
        mix = mix_t'($urandom_range(MIX_NORMAL, MIX_DRAIN));
        next_switch = n_counted + (mix == MIX_FILL ? $urandom_range(100, 200) :
                                                     $urandom_range(40, 120));
      end
      // thresholds: move, button, fetch, command, control, illegal, lone op
      case (mix)
        MIX_FILL:  cut = '{55, 80, 80, 86, 90, 94, 97};
        MIX_DRAIN: cut = '{8, 12, 82, 88, 92, 95, 98};
        default:   cut = '{25, 35, 75, 83, 88, 92, 97};
      endcase
      if (!sb.report_en && $urandom_range(0, 3) != 0) host_command(CMD_ENABLE);
      pick = $urandom_range(0, 99);
      if (pick < cut[0]) begin
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
          // small steps, some just past the overflow limit
          x = sb.last_x + int'($urandom_range(0, 2 * DELTA_SPAN)) - DELTA_SPAN;
          y = sb.last_y + int'($urandom_range(0, 2 * DELTA_SPAN)) - DELTA_SPAN;
        end else if (sel < 17) begin
          x = $urandom;
          y = $urandom;
        end else begin
          x = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
          y = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        end
        move_to(16'(x), 16'(y));
      end else if (pick < cut[1]) begin
        button($urandom_range(0, 1) ? OP_PRESS : OP_RELEASE,
               $urandom_range(0, 4) == 0 ? 3'($urandom_range(0, 7)) :
                                           3'($urandom_range(BCODE_LEFT, BCODE_RIGHT)));
      end else if (pick < cut[2]) begin
        fetch_byte();
      end else if (pick < cut[3]) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) c = CMD_ENABLE;
        else if (sel < 55) c = CMD_DISABLE;
        else if (sel < 65) c = CMD_RESET;
        else c = 8'($urandom);
        host_command(c);
      end else if (pick < cut[4]) begin
        reg_write(REG_CTRL, 8'($urandom));
      end else if (pick < cut[5]) begin
        if ($urandom_range(0, 1)) reg_read(2'($urandom_range(REG_BAD_LO, REG_BAD_HI)));
        else reg_write(2'($urandom_range(REG_BAD_LO, REG_BAD_HI)), 8'($urandom));
      end else if (pick < cut[6]) begin
        // broken sequences: steps of a handshake on their own
        case ($urandom_range(0, 4))
          0: plain(OP_RX_TICK);
          1: plain(OP_TX_DONE);
          2: reg_read(REG_CTRL);
          3: reg_read(REG_DATA);
          default: reg_write(REG_DATA, 8'($urandom));
        endcase
      end else begin
        send(rand_fields(3'($urandom_range(OP_MOVE, OP_UNUSED))));
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions sent, %0d results checked, %0d register reads",
             n_sent, sb.n_checked, sb.n_reads);
    $display("%0d mouse packets queued, %0d writes dropped on a nearly full queue",
             sb.n_packets, sb.n_dropped);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
